### rtl/core/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// Shared types and constants for the touch panel coordinate scaler.
// ----------------------------------------------------------------------------
package tpcs_pkg;

   localparam int WORD_BITS     = 16;   // raw converter word
   localparam int CFG_BITS      = 12;   // calibration and pixel registers
   localparam int PROD_BITS     = 2 * CFG_BITS;  // pixels * offset
   localparam int DIV_STEPS     = PROD_BITS;     // one quotient bit per step
   localparam int STEP_CNT_BITS = 5;
   localparam int CSR_IDX_BITS  = 4;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   typedef logic [CFG_BITS-1:0]     cfg_word_type;

   // register map
   localparam csr_idx_type CSR_READING_MIN = csr_idx_type'(0);
   localparam csr_idx_type CSR_READING_MAX = csr_idx_type'(1);
   localparam csr_idx_type CSR_X_PIXELS    = csr_idx_type'(2);
   localparam csr_idx_type CSR_Y_PIXELS    = csr_idx_type'(3);

   // reset values
   localparam cfg_word_type RST_READING_MIN = cfg_word_type'(200);
   localparam cfg_word_type RST_READING_MAX = cfg_word_type'(1800);
   localparam cfg_word_type RST_X_PIXELS    = cfg_word_type'(240);
   localparam cfg_word_type RST_Y_PIXELS    = cfg_word_type'(320);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_WRITE
   } tpcs_state_type;

   typedef struct packed {
      logic capture;   // take the raw words
      logic load;      // clip, offset, multiply, seed dividers
      logic div_step;  // one restoring division step on both axes
      logic write;     // update held point and present result
   } tpcs_cmd_type;

   typedef struct packed {
      logic out_free;  // result register empty or being taken
   } tpcs_sts_type;

endpackage

### rtl/core/tpcs_req_if.sv
// ----------------------------------------------------------------------------
// tpcs_req_if
// Input channel: one pair of raw converter words per item.
// ----------------------------------------------------------------------------
interface tpcs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_x_word;
   logic [15:0] raw_y_word;

   modport source (output valid, output raw_x_word, output raw_y_word, input ready);
   modport sink   (input valid, input raw_x_word, input raw_y_word, output ready);
endinterface

### rtl/core/tpcs_rsp_if.sv
// ----------------------------------------------------------------------------
// tpcs_rsp_if
// Result channel: held display point and its valid flag.
// ----------------------------------------------------------------------------
interface tpcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] point_x;
   logic [11:0] point_y;
   logic        point_valid;

   modport source (output valid, output point_x, output point_y, output point_valid,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_valid,
                   output ready);
endinterface

### rtl/core/tpcs_csr_if.sv
// ----------------------------------------------------------------------------
// tpcs_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tpcs_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [11:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/tpcs_ctrl.sv
// ----------------------------------------------------------------------------
// tpcs_ctrl
// Sequencer: accept, load, 24 division steps, write back.
// ----------------------------------------------------------------------------
module tpcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output tpcs_pkg::tpcs_cmd_type cmd,
   input  tpcs_pkg::tpcs_sts_type sts
);
   import tpcs_pkg::*;

   localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(DIV_STEPS - 1);

   tpcs_state_type             state_ff, state_in;
   logic [STEP_CNT_BITS-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_WRITE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // step counter never runs past the quotient width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= LAST_STEP)
      else $error("division step count out of range");

   // a captured item always goes straight to the load cycle
   a_capture_load: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_LOAD)
      else $error("capture not followed by load");

   // the last division step hands over to write-back
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == LAST_STEP) |=> state_ff == ST_WRITE)
      else $error("division did not finish into write-back");

   // write-back only into a free result register
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> sts.out_free)
      else $error("write-back over a pending result");

endmodule

### rtl/core/tpcs_datapath.sv
// ----------------------------------------------------------------------------
// tpcs_datapath
// Config registers, clip and offset, per-axis multiply and restoring divide,
// held point doubling as the result register.
// ----------------------------------------------------------------------------
module tpcs_datapath #(
   parameter int READING_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           raw_x_word,
   input  logic [15:0]           raw_y_word,
   input  logic                  csr_valid,
   input  tpcs_pkg::csr_idx_type csr_index,
   input  tpcs_pkg::cfg_word_type csr_data,
   input  tpcs_pkg::tpcs_cmd_type cmd,
   output tpcs_pkg::tpcs_sts_type sts,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [11:0]           point_x,
   output logic [11:0]           point_y,
   output logic                  point_valid
);
   import tpcs_pkg::*;

   localparam int CMP_BITS = (READING_BITS > CFG_BITS) ? READING_BITS : CFG_BITS;

   // config
   cfg_word_type min_ff, min_in, max_ff, max_in;
   cfg_word_type xpix_ff, xpix_in, ypix_ff, ypix_in;
   // captured readings
   logic [READING_BITS-1:0] rd_x_ff, rd_x_in, rd_y_ff, rd_y_in;
   // division lanes: numerator shifts out, quotient shifts in
   logic [PROD_BITS-1:0] num_x_ff, num_x_in, num_y_ff, num_y_in;
   cfg_word_type         rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   cfg_word_type         span_ff, span_in;
   logic                 span_ok_ff, span_ok_in;
   // held point / result register
   cfg_word_type held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic         held_valid_ff, held_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;

   cfg_word_type off_x, off_y, quot_x, quot_y;
   logic         ok;

   // clip to [min, max] and remove the floor
   function automatic cfg_word_type clip_off(input logic [READING_BITS-1:0] rd,
                                             input cfg_word_type lo,
                                             input cfg_word_type hi);
      logic [CMP_BITS-1:0] r, l, h, c;
      r = CMP_BITS'(rd);
      l = CMP_BITS'(lo);
      h = CMP_BITS'(hi);
      c = r;
      if (c < l) c = l;
      if (c > h) c = h;
      return CFG_BITS'(c - l);
   endfunction

   // one restoring step: {remainder, numerator-with-quotient}
   function automatic logic [CFG_BITS+PROD_BITS-1:0] div_step(
         input cfg_word_type rem, input logic [PROD_BITS-1:0] num,
         input cfg_word_type den);
      logic [CFG_BITS:0] trial;
      logic              q;
      trial = {rem, num[PROD_BITS-1]};
      q     = (trial >= {1'b0, den});
      if (q) trial = trial - {1'b0, den};
      return {trial[CFG_BITS-1:0], num[PROD_BITS-2:0], q};
   endfunction

   always_comb begin
      min_in        = min_ff;
      max_in        = max_ff;
      xpix_in       = xpix_ff;
      ypix_in       = ypix_ff;
      rd_x_in       = rd_x_ff;
      rd_y_in       = rd_y_ff;
      num_x_in      = num_x_ff;
      num_y_in      = num_y_ff;
      rem_x_in      = rem_x_ff;
      rem_y_in      = rem_y_ff;
      span_in       = span_ff;
      span_ok_in    = span_ok_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_valid_in = held_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      off_x  = clip_off(rd_x_ff, min_ff, max_ff);
      off_y  = clip_off(rd_y_ff, min_ff, max_ff);
      quot_x = num_x_ff[CFG_BITS-1:0];
      quot_y = num_y_ff[CFG_BITS-1:0];
      ok     = span_ok_ff && (quot_x != '0) && (quot_y != '0);

      if (csr_valid) begin
         case (csr_index)
            CSR_READING_MIN: min_in  = csr_data;
            CSR_READING_MAX: max_in  = csr_data;
            CSR_X_PIXELS:    xpix_in = csr_data;
            CSR_Y_PIXELS:    ypix_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         rd_x_in = raw_x_word[WORD_BITS-1 -: READING_BITS];
         rd_y_in = raw_y_word[WORD_BITS-1 -: READING_BITS];
      end

      if (cmd.load) begin
         num_x_in   = PROD_BITS'(xpix_ff) * PROD_BITS'(off_x);
         num_y_in   = PROD_BITS'(ypix_ff) * PROD_BITS'(off_y);
         rem_x_in   = '0;
         rem_y_in   = '0;
         span_in    = max_ff - min_ff;
         span_ok_in = max_ff > min_ff;
      end

      if (cmd.div_step) begin
         {rem_x_in, num_x_in} = div_step(rem_x_ff, num_x_ff, span_ff);
         {rem_y_in, num_y_in} = div_step(rem_y_ff, num_y_ff, span_ff);
      end

      if (cmd.write) begin
         rsp_valid_in = 1'b1;
         if (ok) begin
            held_x_in     = xpix_ff - quot_x;
            held_y_in     = quot_y;
            held_valid_in = 1'b1;
         end else begin
            held_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff        <= RST_READING_MIN;
         max_ff        <= RST_READING_MAX;
         xpix_ff       <= RST_X_PIXELS;
         ypix_ff       <= RST_Y_PIXELS;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         span_ok_ff    <= 1'b0;
      end else begin
         min_ff        <= min_in;
         max_ff        <= max_in;
         xpix_ff       <= xpix_in;
         ypix_ff       <= ypix_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         span_ok_ff    <= span_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff  <= rd_x_in;
      rd_y_ff  <= rd_y_in;
      num_x_ff <= num_x_in;
      num_y_ff <= num_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      span_ff  <= span_in;
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign point_x      = held_x_ff;
   assign point_y      = held_y_ff;
   assign point_valid  = held_valid_ff;

endmodule

### rtl/core/touch_panel_coordinate_scaler_core.sv
// ----------------------------------------------------------------------------
// touch_panel_coordinate_scaler_core
// Sequence after the input item is accepted: load/multiply, 24 division steps,
//   then write-back into the registered result.
// A new item is accepted only after write-back of the previous one; the pace is
//   set by the 24-step restoring divider, and rsp_ stalls stretch write-back.
// A new item is taken while the previous result still waits on rsp_.
// Reset (synchronous, active high): calibration back to defaults, held point 0.
// ----------------------------------------------------------------------------
module touch_panel_coordinate_scaler_core #(
   parameter int READING_BITS = 12   // converter bits taken from the top of the word
) (
   input  logic       clock,
   input  logic       reset,
   tpcs_req_if.sink   req_chan,
   tpcs_rsp_if.source rsp_chan,
   tpcs_csr_if.sink   csr_chan
);
   import tpcs_pkg::*;

   tpcs_cmd_type cmd;
   tpcs_sts_type sts;

   // register writes are always taken; software must write only while idle, not enforced here
   assign csr_chan.ready = 1'b1;

   // sequencer: owns the input handshake and the step count
   tpcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: config, clip, multiply, two divider lanes, held point
   tpcs_datapath #(
      .READING_BITS (READING_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .raw_x_word  (req_chan.raw_x_word),
      .raw_y_word  (req_chan.raw_y_word),
      .csr_valid   (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .point_x     (rsp_chan.point_x),
      .point_y     (rsp_chan.point_y),
      .point_valid (rsp_chan.point_valid)
   );

endmodule
